// ===== rtl/core/bounded_set_span_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the span tracker
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_SPAN_TRACKER_MACROS_SVH
`define BOUNDED_SET_SPAN_TRACKER_MACROS_SVH

// same-cycle implication
`define BSST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BSST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared widths, defaults and the sequencer state type of the span tracker.
// ----------------------------------------------------------------------------
package bsst_pkg;

	localparam int DATA_W       = 32;
	localparam int CFG_W        = 7;
	localparam int CAPACITY_DEF = 64;

	localparam logic [CFG_W-1:0] CAPACITY_RST = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/bounded_set_span_tracker.sv =====
// ----------------------------------------------------------------------------
// bounded_set_span_tracker
// Bounded store of signed values tracking the closest and farthest pair.
// ----------------------------------------------------------------------------
// One value is taken at a time. A value that finds n values already held
// is compared against each of them through the single read port of the value
// RAM, one read per cycle, and holds the block until the compare pipeline has
// drained; a value rejected as full or met by an empty store skips the scan.
// The result then waits in the output register until taken, and the next
// value is accepted once the sequencer is back in idle. The limit is the
// capacity register, saturated at CAPACITY; lowering it below the fill keeps
// the held values. The value RAM needs no clearing after reset, since only
// entries below the fill count are read.
// ----------------------------------------------------------------------------
`include "bounded_set_span_tracker_macros.svh"

module bounded_set_span_tracker #(
	parameter int CAPACITY = bsst_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsst_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [bsst_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic                              enough,
	output logic [bsst_pkg::DATA_W-1:0]       shortest_span,
	output logic [bsst_pkg::DATA_W-1:0]       longest_span
);

	localparam int DW = bsst_pkg::DATA_W;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > bsst_pkg::CFG_W) ? CW : bsst_pkg::CFG_W;

	bsst_pkg::state_t state_q, state_n;

	logic [bsst_pkg::CFG_W-1:0] capacity_q;
	logic [CW-1:0]              count_q;
	logic signed [DW-1:0]       least_q, greatest_q;
	logic [DW-1:0]              gap_q;
	logic signed [DW-1:0]       value_q;
	logic                       full_q;
	logic [AW-1:0]              rd_idx_q;
	logic                       vld_s1, vld_s2;
	logic [DW-1:0]              dist_s2;
	logic                       out_valid_q;
	logic                       status_q, enough_q;
	logic [DW-1:0]              shortest_q, longest_q;

	logic [LW-1:0]        lim;
	logic                 full_now;
	logic                 accept;
	logic                 out_free;
	logic                 commit;
	logic                 mem_we;
	logic [DW-1:0]        rd_data;
	logic signed [DW:0]   diff;
	logic [DW-1:0]        dist_n;
	logic signed [DW-1:0] least_n, greatest_n;
	logic [CW-1:0]        count_n;
	logic [AW-1:0]        last_idx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= bsst_pkg::CAPACITY_RST;
		end else if (cfg_valid) begin
			capacity_q <= cfg_data;
		end
	end

	assign lim      = (LW'(capacity_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(capacity_q);
	assign full_now = LW'(count_q) >= lim;
	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != bsst_pkg::ST_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign commit   = (state_q == bsst_pkg::ST_DONE) && out_free;
	assign mem_we   = commit && !full_q;
	assign last_idx = AW'(count_q - CW'(1));

	bsst_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_values (
		.clk   (clk),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (value_q),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	always_comb begin
		state_n = state_q;
		case (state_q)
			bsst_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (full_now || count_q == '0) begin
						state_n = bsst_pkg::ST_DONE;
					end else begin
						state_n = bsst_pkg::ST_SCAN;
					end
				end
			end
			bsst_pkg::ST_SCAN: begin
				if (rd_idx_q == last_idx) begin
					state_n = bsst_pkg::ST_DRAIN;
				end
			end
			bsst_pkg::ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_n = bsst_pkg::ST_DONE;
				end
			end
			bsst_pkg::ST_DONE: begin
				if (out_free) begin
					state_n = bsst_pkg::ST_IDLE;
				end
			end
			default: state_n = bsst_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsst_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// item capture and read sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			vld_s1 <= state_q == bsst_pkg::ST_SCAN;
			vld_s2 <= vld_s1;
			if (accept) begin
				rd_idx_q <= '0;
			end else if (state_q == bsst_pkg::ST_SCAN) begin
				rd_idx_q <= rd_idx_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			full_q  <= full_now;
		end
	end

	// distance stage
	assign diff   = {value_q[DW-1], value_q} - {rd_data[DW-1], rd_data};
	assign dist_n = diff[DW] ? (rd_data - value_q) : (value_q - rd_data);

	always_ff @(posedge clk) begin
		dist_s2 <= dist_n;
	end

	assign least_n    = (count_q == '0 || value_q < least_q) ? value_q : least_q;
	assign greatest_n = (count_q == '0 || value_q > greatest_q) ? value_q : greatest_q;
	assign count_n    = count_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			least_q    <= '0;
			greatest_q <= '0;
			gap_q      <= '1;
		end else begin
			if (vld_s2 && dist_s2 < gap_q) begin
				gap_q <= dist_s2;
			end
			if (mem_we) begin
				count_q    <= count_n;
				least_q    <= least_n;
				greatest_q <= greatest_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= full_q;
			if (full_q) begin
				enough_q   <= count_q >= CW'(2);
				shortest_q <= (count_q >= CW'(2)) ? gap_q : '0;
				longest_q  <= (count_q >= CW'(2)) ? DW'(greatest_q - least_q) : '0;
			end else begin
				enough_q   <= count_n >= CW'(2);
				shortest_q <= (count_n >= CW'(2)) ? gap_q : '0;
				longest_q  <= (count_n >= CW'(2)) ? DW'(greatest_n - least_n) : '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign enough        = enough_q;
	assign shortest_span = shortest_q;
	assign longest_span  = longest_q;

	`BSST_ASSERT_NOW(a_scan_in_range, state_q == bsst_pkg::ST_SCAN, rd_idx_q < AW'(count_q), "scan read beyond fill")
	`BSST_ASSERT_NOW(a_write_below_limit, mem_we, LW'(count_q) < lim, "write to a full store")
	`BSST_ASSERT_NEXT(a_count_step, mem_we, count_q == $past(count_q) + CW'(1), "fill count did not step")
	`BSST_ASSERT_NEXT(a_gap_monotone, 1'b1, gap_q <= $past(gap_q), "shortest gap grew")
	`BSST_ASSERT_NEXT(a_result_loaded, commit, out_valid_q, "result not presented after commit")

endmodule

// ===== rtl/core/bsst_ram.sv =====
// ----------------------------------------------------------------------------
// bsst_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bsst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
